// ===== design/saat_pkg.sv =====
`timescale 1ns / 1ps

package saat_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 128;
    localparam int ADDR_W = 64;
    localparam int SHORT_W = 16;
    localparam int COUNT_W = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic [SHORT_W-1:0] REJECT_RESET = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // search token handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               hit;
        logic               free;
        logic [SHORT_W-1:0] idx;
    } tok_t;

    // slot write, seen by every cell
    typedef struct packed {
        logic               en;
        logic [SHORT_W-1:0] idx;
        logic [ADDR_W-1:0]  addr;
    } wr_t;

endpackage

// ===== design/saat_cell.sv =====
`timescale 1ns / 1ps

module saat_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  saat_pkg::tok_t              tok_in,
    input  logic [saat_pkg::ADDR_W-1:0] req_addr,
    input  saat_pkg::wr_t               wr,
    output saat_pkg::tok_t              tok_out
);

    localparam logic [saat_pkg::SHORT_W-1:0] MY_IDX = saat_pkg::SHORT_W'(CELL_IDX);

    logic                        valid_reg;
    logic [saat_pkg::ADDR_W-1:0] addr_reg;
    saat_pkg::tok_t              tok_reg;
    saat_pkg::tok_t              tok_next;
    logic                        match;
    logic                        wr_here;

    assign match   = valid_reg && (addr_reg == req_addr);
    assign wr_here = wr.en && (wr.idx == MY_IDX);

    // lowest hit wins; otherwise remember the lowest free slot
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.hit)
        begin
            if (match)
            begin
                tok_next.hit = 1'b1;
                tok_next.idx = MY_IDX;
            end
            else if (!valid_reg && !tok_in.free)
            begin
                tok_next.free = 1'b1;
                tok_next.idx  = MY_IDX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_here)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            addr_reg <= wr.addr;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/short_address_assign_table_core.sv =====
`timescale 1ns / 1ps
// A request is registered and injected as a token at the head of the search
// chain; the token passes through the register of each slot cell, then the
// finish state registers the result. One request is searched at a time; a new
// request is taken while the previous result waits on the master side.
// Reset (rst_n, async low): all slots invalid, count zero, reject address 0xFFFF.

module short_address_assign_table_core #(
    parameter int TABLE_ENTRIES = saat_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: [63:0] device_ext_addr
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [saat_pkg::ADDR_W-1:0]     s_tdata,
    // m_tdata: [15:0] nwk_addr, [16] granted, [17] newly_assigned,
    //          [25:18] device_count, [31:26] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [saat_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [saat_pkg::SHORT_W-1:0]    cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic                           start_reg;
    logic [saat_pkg::ADDR_W-1:0]    req_addr_reg;
    saat_pkg::tok_t                 fin_reg;
    logic [saat_pkg::COUNT_W-1:0]   used_count_reg;
    logic [saat_pkg::COUNT_W-1:0]   used_count_next;
    logic [saat_pkg::SHORT_W-1:0]   reject_reg;
    logic                           m_tvalid_reg;
    logic [saat_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [saat_pkg::OUT_DATA_W-1:0] m_tdata_next;

    saat_pkg::tok_t                 tok_w [0:TABLE_ENTRIES];
    saat_pkg::wr_t                  wr;
    logic                           out_free;
    logic                           finish_go;
    logic                           claim;
    logic [saat_pkg::SHORT_W-1:0]   slot_short;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish_go = (state_reg == ST_FINISH) && out_free;
    assign claim = !fin_reg.hit && fin_reg.free;
    assign slot_short = fin_reg.idx + saat_pkg::SHORT_W'(1);

    assign tok_w[0] = '{active: start_reg, hit: 1'b0, free: 1'b0, idx: '0};

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        saat_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok_w[i]),
            .req_addr (req_addr_reg),
            .wr       (wr),
            .tok_out  (tok_w[i+1])
        );
    end

    always_comb
    begin
        wr.en   = finish_go && claim;
        wr.idx  = fin_reg.idx;
        wr.addr = req_addr_reg;
    end

    always_comb
    begin
        used_count_next = used_count_reg;
        if (claim && (used_count_reg != saat_pkg::COUNT_MAX))
        begin
            used_count_next = used_count_reg + saat_pkg::COUNT_W'(1);
        end
    end

    always_comb
    begin
        m_tdata_next = '0;
        if (fin_reg.hit)
        begin
            m_tdata_next[15:0]  = slot_short;
            m_tdata_next[16]    = 1'b1;
            m_tdata_next[25:18] = used_count_reg;
        end
        else if (fin_reg.free)
        begin
            m_tdata_next[15:0]  = slot_short;
            m_tdata_next[16]    = 1'b1;
            m_tdata_next[17]    = 1'b1;
            m_tdata_next[25:18] = used_count_next;
        end
        else
        begin
            m_tdata_next[15:0]  = reject_reg;
            m_tdata_next[25:18] = used_count_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tok_w[TABLE_ENTRIES].active)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_reg      <= 1'b0;
            used_count_reg <= '0;
            reject_reg     <= saat_pkg::REJECT_RESET;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= s_tvalid && s_tready;
            if (cfg_we)
            begin
                reject_reg <= cfg_wdata;
            end
            if (finish_go)
            begin
                used_count_reg <= used_count_next;
                m_tvalid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_addr_reg <= s_tdata;
        end
        if ((state_reg == ST_SEARCH) && tok_w[TABLE_ENTRIES].active)
        begin
            fin_reg <= tok_w[TABLE_ENTRIES];
        end
        if (finish_go)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // only one token in the chain, and only while searching
    a_start_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (state_reg == ST_SEARCH))
        else $error("token injected outside search");

    a_chain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SEARCH) |-> !tok_w[TABLE_ENTRIES].active)
        else $error("token left the chain outside search");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(used_count_reg) <= TABLE_ENTRIES) || (used_count_reg == saat_pkg::COUNT_MAX))
        else $error("device count above table size");

    a_reuse_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && !claim) |=> $stable(used_count_reg))
        else $error("count changed without a new slot");

    a_claim_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && claim && (used_count_reg != saat_pkg::COUNT_MAX))
        |=> (used_count_reg == $past(used_count_reg) + saat_pkg::COUNT_W'(1)))
        else $error("new slot not counted");

endmodule
